@@ src/calendar_clock_tick_assert.svh @@
// ----------------------------------------------------------------------------
// calendar_clock_tick assertion macros
// shared property forms, clocked on clock and quiet while reset is high
// ----------------------------------------------------------------------------
`ifndef CALENDAR_CLOCK_TICK_ASSERT_SVH
`define CALENDAR_CLOCK_TICK_ASSERT_SVH

// condition in this cycle implies consequence in the same cycle
`define CCT_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cct assertion failed");

// condition in this cycle implies consequence in the next cycle
`define CCT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cct assertion failed");

`endif

@@ src/cct_pkg.sv @@
// ----------------------------------------------------------------------------
// cct_pkg
// types, limits and the month length table of the calendar counter
// ----------------------------------------------------------------------------
`default_nettype none

package cct_pkg;

   // item kinds carried on tuser
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // bus widths
   localparam int TIME_W  = 36;
   localparam int TDATA_W = 40;

   // last legal value of each counter
   localparam logic [5:0] SECOND_LAST  = 6'd59;
   localparam logic [5:0] MINUTE_LAST  = 6'd59;
   localparam logic [4:0] HOUR_LAST    = 5'd23;
   localparam logic [2:0] WEEKDAY_LAST = 3'd6;
   localparam logic [3:0] MONTH_LAST   = 4'd12;
   localparam logic [6:0] YEAR_LAST    = 7'd99;
   localparam logic [3:0] MONTH_FEB    = 4'd2;

   // full date and time, weekday in the lowest bits
   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [2:0] weekday;
   } time_type;

   // saturday, january 1 of year 0, midnight
   localparam time_type TIME_RESET = '{
      second:  6'd0,
      minute:  6'd0,
      hour:    5'd0,
      year:    7'd0,
      month:   4'd1,
      day:     5'd1,
      weekday: 3'd0
   };

   // days in a month; codes without meaning count as 31
   function automatic logic [4:0] month_days(input logic [3:0] month,
                                             input logic [6:0] year);
      logic [4:0] len;
      case (month)
         4'd2:    len = (year[1:0] == 2'b00) ? 5'd29 : 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ src/calendar_clock_tick.sv @@
// Calendar counter: every item on req either loads a full date and time
// (req_tuser high) or advances the clock by one second (req_tuser low), and
// returns one item on rsp with the counter value after that change. One item
// is taken every clock cycle while rsp takes its results. An accepted item
// waits in the input register until the result register is free, and its
// new counter value is then registered and presented on rsp. The counter
// register is also the result register, and the carry chain and month length
// lookup sit between the two registers. When rsp stalls, one further item
// waits in the input register before req_tready drops.
`default_nettype none

// ----------------------------------------------------------------------------
// calendar_clock_tick
// second, minute, hour, weekday, day, month and two-digit year counter
// ----------------------------------------------------------------------------
module calendar_clock_tick import cct_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   // request stream
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // set_weekday, set_day, set_month, set_year, set_hour, set_minute,
   // set_second, zero fill
   input  wire logic [TDATA_W-1:0] req_tdata,
   // op
   input  wire logic               req_tuser,
   // response stream
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // weekday_out, day_out, month_out, year_out, hour_out, minute_out,
   // second_out, zero fill
   output logic [TDATA_W-1:0]      rsp_tdata
);

`include "calendar_clock_tick_assert.svh"

   logic     s1_valid_ff;
   logic     s1_valid_in;
   logic     s1_op_ff;
   time_type s1_load_ff;
   logic     rsp_valid_ff;
   logic     rsp_valid_in;
   time_type time_ff;
   time_type time_in;
   logic     advance;
   logic     req_take;

   // handshake
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   // input stage control
   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // result stage control
   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // counter update
   cct_next u_next (
      .op   (s1_op_ff),
      .cur  (time_ff),
      .load (s1_load_ff),
      .nxt  (time_in)
   );

   // control and counter registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         time_ff      <= TIME_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            time_ff <= time_in;
         end
      end
   end

   // input payload register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= req_tuser;
         s1_load_ff <= req_tdata[TIME_W-1:0];
      end
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(TDATA_W-TIME_W){1'b0}}, time_ff};

   // checks
   `CCT_ASSERT_NEXT(a_stall_holds, rsp_valid_ff && !rsp_tready,
      rsp_valid_ff && $stable(time_ff))
   `CCT_ASSERT_NEXT(a_load_lands, advance && (s1_op_ff == OP_LOAD),
      time_ff == $past(s1_load_ff))
   `CCT_ASSERT_NEXT(a_second_steps,
      advance && (s1_op_ff == OP_TICK) && (time_ff.second < SECOND_LAST),
      (time_ff.second == $past(time_ff.second) + 6'd1) &&
      (time_ff.minute == $past(time_ff.minute)))
   `CCT_ASSERT_SAME(a_ready_cause, !req_tready,
      s1_valid_ff && rsp_valid_ff && !rsp_tready)

endmodule

`default_nettype wire

@@ src/cct_next.sv @@
// ----------------------------------------------------------------------------
// cct_next
// next counter value for one item: a load or a one second carry chain
// ----------------------------------------------------------------------------
`default_nettype none

module cct_next import cct_pkg::*; (
   input  wire logic     op,
   input  wire time_type cur,
   input  wire time_type load,
   output time_type      nxt
);

   logic       sec_wrap;
   logic       min_wrap;
   logic       hour_wrap;
   logic       month_end;
   time_type   tick;

   // carry terms of the chain
   assign sec_wrap  = (cur.second >= SECOND_LAST);
   assign min_wrap  = sec_wrap && (cur.minute >= MINUTE_LAST);
   assign hour_wrap = min_wrap && (cur.hour >= HOUR_LAST);
   assign month_end = (cur.day >= month_days(cur.month, cur.year));

   // one second later
   always_comb begin
      tick = cur;
      tick.second = sec_wrap ? 6'd0 : cur.second + 6'd1;
      if (sec_wrap) begin
         tick.minute = (cur.minute >= MINUTE_LAST) ? 6'd0 : cur.minute + 6'd1;
      end
      if (min_wrap) begin
         tick.hour = (cur.hour >= HOUR_LAST) ? 5'd0 : cur.hour + 5'd1;
      end
      // day advance
      if (hour_wrap) begin
         tick.weekday = (cur.weekday >= WEEKDAY_LAST) ? 3'd0 : cur.weekday + 3'd1;
         if (month_end) begin
            tick.day = 5'd1;
            if (cur.month >= MONTH_LAST) begin
               tick.month = 4'd1;
               tick.year  = (cur.year >= YEAR_LAST) ? 7'd0 : cur.year + 7'd1;
            end else begin
               tick.month = cur.month + 4'd1;
            end
         end else begin
            tick.day = cur.day + 5'd1;
         end
      end
   end

   // pick load or tick
   always_comb begin
      case (op)
         OP_LOAD: nxt = load;
         OP_TICK: nxt = tick;
         default: nxt = tick;
      endcase
   end

endmodule

`default_nettype wire
